@@ hw/rtl/pms_pkg.sv @@
// ============================================================================
// pms_pkg
// Shared types, constants and the boundary power function of the powersort
// merge scheduler.
// ============================================================================
package pms_pkg;

    localparam int OFS_W       = 10;   // run begin / merge mid offsets
    localparam int END_W       = 11;   // exclusive end offsets
    localparam int POW_W       = 4;    // boundary power
    localparam int MAX_LEN     = 1024; // array length limit, ends saturate here
    localparam int STACK_DEPTH = 11;   // stack entries, entry 0 is the sentinel

    // power given to a zero XOR
    localparam logic [POW_W-1:0] POW_ZERO_XOR = 4'd12;

    // one stack entry
    typedef struct packed {
        logic [OFS_W-1:0] run_begin;
        logic [POW_W-1:0] run_power;
    } stack_entry_t;

    // one merge command, packed lowest field last
    typedef struct packed {
        logic [END_W-1:0] merge_end;
        logic [OFS_W-1:0] merge_mid;
        logic [OFS_W-1:0] merge_begin;
    } merge_cmd_t;

    // 1 + index of the lowest set bit of a ^ b
    function automatic logic [POW_W-1:0] boundary_power(
        input logic [OFS_W-1:0] a,
        input logic [END_W-1:0] b
    );
        logic [END_W-1:0] x;
        logic [POW_W-1:0] n;
        logic             found;
        x     = {1'b0, a} ^ b;
        n     = POW_ZERO_XOR;
        found = 1'b0;
        for (int i = 0; i < END_W; i++)
        begin
            if (!found && x[i])
            begin
                n     = POW_W'(i + 1);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/powersort_merge_scheduler_core.sv @@
// ============================================================================
// powersort_merge_scheduler_core
// Powersort merge scheduler: takes natural run ends, keeps a power stack in
// a synchronous RAM and issues merge commands in powersort order.
// ============================================================================
//
//  channel  | dir | tdata (low bit up)                        | tlast        | tuser
//  ---------+-----+-------------------------------------------+--------------+----------
//  s_axis   | in  | run_end[10:0], 5'b0 pad                   | is_last_run  | -
//  m_axis   | out | merge_begin[9:0], merge_mid[9:0],         | last_of_step | sort_done
//           |     | merge_end[10:0], 1'b0 pad                 |              |
//
//  Steps: a run end that is dropped (first run, or end not past the current
//  end) is handled in S_IDLE alone. Otherwise: accept in S_IDLE, S_READ
//  examines stack entries (each pop, plus the final compare), S_PUSH when a
//  full stack forces a pop, S_DONE releases the last command; a last run adds
//  the S_FLUSH_RD RAM turnaround and an S_FLUSH pop per flushed entry. The pop
//  rate is set by the single RAM read port: one entry/cycle unless stalled.
//  Reset: rst_n async, clears stack pointer, current run and all handshakes;
//  RAM needs no clearing since every entry is pushed before its data is used.
//  Stalls: commands pass a one-deep pending slot and an output register; the
//  pop loop halts while both are full and m_axis_tready is low.
// ============================================================================
module powersort_merge_scheduler_core
    import pms_pkg::*;
#(
    parameter int STACK_DEPTH_P = STACK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // run end requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // run_end[10:0], pad
    input  logic        s_axis_tlast,   // is_last_run
    // merge command requests
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // merge_begin[9:0], merge_mid[9:0], merge_end[10:0], pad
    output logic        m_axis_tlast,   // last_of_step
    output logic [0:0]  m_axis_tuser    // sort_done
);

    localparam int PTR_W = $clog2(STACK_DEPTH_P);
    localparam logic [PTR_W-1:0] TOP_FULL = PTR_W'(STACK_DEPTH_P - 1);
    localparam logic [PTR_W-1:0] TOP_ONE  = PTR_W'(1);
    localparam logic [END_W-1:0] END_MAX  = END_W'(MAX_LEN);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,  // wait for a run end
        S_READ     = 6'b000010,  // pop while top power >= new power
        S_PUSH     = 6'b000100,  // push after a forced pop
        S_FLUSH_RD = 6'b001000,  // RAM turnaround after the push
        S_FLUSH    = 6'b010000,  // pop everything on the last run
        S_DONE     = 6'b100000   // release the pending command as step end
    } state_t;

    state_t           state_reg,      state_next;
    logic [PTR_W-1:0] top_reg,        top_next;
    logic [OFS_W-1:0] cur_begin_reg,  cur_begin_next;
    logic [END_W-1:0] cur_end_reg,    cur_end_next;
    logic             have_reg,       have_next;
    logic [END_W-1:0] new_end_reg,    new_end_next;
    logic             last_reg,       last_next;
    logic [POW_W-1:0] pow_reg,        pow_next;
    logic             done_reg,       done_next;
    logic             pend_valid_reg, pend_valid_next;
    merge_cmd_t       pend_reg,       pend_next;
    logic             out_valid_reg,  out_valid_next;
    merge_cmd_t       out_reg,        out_next;
    logic             out_last_reg,   out_last_next;
    logic             out_done_reg,   out_done_next;

    // stack RAM port signals
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    stack_entry_t     wr_data;
    stack_entry_t     rd_q;

    logic             accept;
    logic [END_W-1:0] in_end;
    logic             can_move;
    logic             stall;
    logic             emit;
    merge_cmd_t       pop_cmd;

    pms_stack_ram #(
        .DEPTH (STACK_DEPTH_P),
        .PTR_W (PTR_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (top_next),     // always prefetch the next top entry
        .rd_data (rd_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_end        = (s_axis_tdata[END_W-1:0] > END_MAX) ? END_MAX
                                                               : s_axis_tdata[END_W-1:0];

    // output register frees up this cycle
    assign can_move = !out_valid_reg || m_axis_tready;
    // pending slot full and cannot drain
    assign stall    = pend_valid_reg && !can_move;

    assign pop_cmd.merge_begin = rd_q.run_begin;
    assign pop_cmd.merge_mid   = cur_begin_reg;
    assign pop_cmd.merge_end   = cur_end_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        cur_begin_next  = cur_begin_reg;
        cur_end_next    = cur_end_reg;
        have_next       = have_reg;
        new_end_next    = new_end_reg;
        last_next       = last_reg;
        pow_next        = pow_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        wr_en           = 1'b0;
        wr_addr         = top_reg + TOP_ONE;
        wr_data         = '{run_begin: cur_begin_reg, run_power: pow_reg};
        emit            = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!have_reg)
                    begin
                        // first run opens [0, end); a lone last run leaves reset state
                        if (in_end != '0 && !s_axis_tlast)
                        begin
                            cur_begin_next = '0;
                            cur_end_next   = in_end;
                            have_next      = 1'b1;
                        end
                    end
                    else if (in_end > cur_end_reg)
                    begin
                        new_end_next = in_end;
                        last_next    = s_axis_tlast;
                        pow_next     = boundary_power(cur_begin_reg, cur_end_reg);
                        state_next   = S_READ;
                    end
                end
            end

            S_READ:
            begin
                if (!stall)
                begin
                    if (top_reg != '0 && rd_q.run_power >= pow_reg)
                    begin
                        emit           = 1'b1;
                        cur_begin_next = rd_q.run_begin;
                        top_next       = top_reg - TOP_ONE;
                    end
                    else if (top_reg == TOP_FULL)
                    begin
                        // full stack: merge the top entry to make room
                        emit           = 1'b1;
                        cur_begin_next = rd_q.run_begin;
                        top_next       = top_reg - TOP_ONE;
                        state_next     = S_PUSH;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        top_next       = top_reg + TOP_ONE;
                        cur_begin_next = cur_end_reg[OFS_W-1:0];
                        cur_end_next   = new_end_reg;
                        state_next     = last_reg ? S_FLUSH_RD : S_DONE;
                    end
                end
            end

            S_PUSH:
            begin
                wr_en          = 1'b1;
                top_next       = top_reg + TOP_ONE;
                cur_begin_next = cur_end_reg[OFS_W-1:0];
                cur_end_next   = new_end_reg;
                state_next     = last_reg ? S_FLUSH_RD : S_DONE;
            end

            S_FLUSH_RD:
            begin
                state_next = S_FLUSH;
            end

            S_FLUSH:
            begin
                if (!stall)
                begin
                    emit           = 1'b1;
                    cur_begin_next = rd_q.run_begin;
                    top_next       = top_reg - TOP_ONE;
                    if (top_reg == TOP_ONE)
                    begin
                        // array complete, back to reset state
                        done_next      = 1'b1;
                        have_next      = 1'b0;
                        cur_begin_next = '0;
                        cur_end_next   = '0;
                        state_next     = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!pend_valid_reg)
                begin
                    done_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (can_move)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_done_next   = done_reg;
                    pend_valid_next = 1'b0;
                    done_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // new command goes to the pending slot; the older one moves out
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_done_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = pop_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= '0;
            cur_begin_reg  <= '0;
            cur_end_reg    <= '0;
            have_reg       <= 1'b0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            cur_begin_reg  <= cur_begin_next;
            cur_end_reg    <= cur_end_next;
            have_reg       <= have_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        new_end_reg  <= new_end_next;
        last_reg     <= last_next;
        pow_reg      <= pow_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

endmodule

@@ hw/rtl/pms_stack_ram.sv @@
// ============================================================================
// pms_stack_ram
// Run stack storage: one write port, one read port, registered read data.
// ============================================================================
module pms_stack_ram
    import pms_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH,
    parameter int PTR_W = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [PTR_W-1:0]   wr_addr,
    input  stack_entry_t       wr_data,
    input  logic [PTR_W-1:0]   rd_addr,
    output stack_entry_t       rd_data
);

    stack_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read before write on a same-address collision
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
